// File: rtl/core/q2bdp_pkg.sv
// Package for the 2-bit block quantized dot product: item types and constants.
`timescale 1ns / 1ps
`default_nettype none

package q2bdp_pkg;

  // Binary16 field layout and the special-value substitutes.
  localparam int unsigned HalfExpW  = 5;
  localparam int unsigned HalfManW  = 10;
  localparam logic [HalfExpW-1:0] HalfExpMax = 5'd31;
  localparam logic [HalfExpW-1:0] HalfExpSub = 5'd0;
  // Infinity and NaN decode as 65504 = 2047 * 2^5, i.e. 2047 << 29 in 2^-24 units.
  localparam logic [HalfManW:0]   InfMant    = 11'd2047;
  localparam logic [HalfExpW-1:0] InfShift   = 5'd29;

  // Widths along the datapath.
  localparam int unsigned MantW  = HalfManW + 1;   // 11-bit significand
  localparam int unsigned WMantW = MantW + 2;      // times 3 at most
  localparam int unsigned ActW   = 32;
  localparam int unsigned ProdW  = WMantW + ActW;  // 45
  localparam int unsigned WideW  = ProdW + 29;     // after the largest exponent shift
  localparam int unsigned FracDrop = 25;           // 2^-41 units down to Q16.16
  localparam int unsigned TermW  = WideW - FracDrop;
  localparam int unsigned SumW   = 64;

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  typedef struct packed {
    logic [1:0]               weight_code;
    logic [15:0]              scale_half;
    logic signed [ActW-1:0]   activation;
    logic                     last_element;
  } in_item_t;

  typedef struct packed {
    logic signed [SumW-1:0]   dot_product;
    logic                     overflowed;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/core/q2_block_dot_product.sv
// Streaming 2-bit block quantized dot product with saturating Q48.16 accumulator.
// Pipeline: input, product and term regs, then the result reg; a row's result
//   follows its last item only.
// Throughput: one item per cycle; the only stall comes from a held result meeting
//   another row end, which backs up through the pipeline.
// Reset: clears all stage valids, the running sum and the overflow flag.
`timescale 1ns / 1ps
`default_nettype none

module q2_block_dot_product (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire q2bdp_pkg::in_item_t  in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output q2bdp_pkg::out_item_t      out_item_o
);
  import q2bdp_pkg::*;

  // Stage valids.
  logic s0_v_q, s0_v_d, s1_v_q, s1_v_d, s2_v_q, s2_v_d, out_v_q, out_v_d;
  logic s0_rdy, s1_rdy, s2_rdy, s0_go, s1_go, acc_go, accept;

  // Stage payloads.
  in_item_t                  s0_q;
  logic [ProdW-1:0]          s1_prod_q, s1_prod_d;
  logic [HalfExpW-1:0]       s1_sh_q, s1_sh_d;
  logic                      s1_neg_q, s1_neg_d, s1_last_q;
  logic signed [SumW-1:0]    s2_term_q, s2_term_d;
  logic                      s2_last_q;
  out_item_t                 out_q;

  // Accumulator state.
  logic signed [SumW-1:0]    sum_q, sum_d, sum_new;
  logic                      flag_q, flag_d, flag_new;

  // Decode and multiply signals.
  logic [HalfExpW-1:0]       exp_f;
  logic [HalfManW-1:0]       man_f;
  logic [MantW-1:0]          mant;
  logic [WMantW-1:0]         wmant;
  logic                      wneg, aneg;
  logic [ActW-1:0]           amag;

  // Shift and accumulate signals.
  logic [WideW-1:0]          wide;
  logic [TermW-1:0]          pmag;
  logic signed [SumW:0]      sum_ext;
  logic                      ovf;

  // Handshake: a stage moves when the next one is free or moving.
  assign acc_go = s2_v_q && (!s2_last_q || !out_v_q || !out_stall_i);
  assign s2_rdy = !s2_v_q || acc_go;
  assign s1_go  = s1_v_q && s2_rdy;
  assign s1_rdy = !s1_v_q || s2_rdy;
  assign s0_go  = s0_v_q && s1_rdy;
  assign s0_rdy = !s0_v_q || s1_rdy;
  assign accept = in_valid_i && s0_rdy;
  assign in_stall_o = !s0_rdy;

  always_comb begin
    s0_v_d  = accept | (s0_v_q & ~s0_go);
    s1_v_d  = s0_go  | (s1_v_q & ~s1_go);
    s2_v_d  = s1_go  | (s2_v_q & ~acc_go);
    out_v_d = out_v_q & out_stall_i;
    if (acc_go && s2_last_q) begin
      out_v_d = 1'b1;
    end
  end

  // Stage 1: decode the half scale, form (2*code-3)*mant and multiply by |activation|.
  always_comb begin
    exp_f = s0_q.scale_half[14:10];
    man_f = s0_q.scale_half[9:0];
    if (exp_f == HalfExpSub) begin
      mant    = {1'b0, man_f};
      s1_sh_d = '0;
    end else if (exp_f == HalfExpMax) begin
      mant    = InfMant;
      s1_sh_d = InfShift;
    end else begin
      mant    = {1'b1, man_f};
      s1_sh_d = exp_f - HalfExpW'(1);
    end
    case (s0_q.weight_code)
      2'd0, 2'd3: wmant = {1'b0, mant, 1'b0} + {2'b00, mant};
      default:    wmant = {2'b00, mant};
    endcase
    wneg = (s0_q.weight_code[1] == 1'b0) ^ s0_q.scale_half[15];
    aneg = s0_q.activation[ActW-1];
    amag = aneg ? (~s0_q.activation + ActW'(1)) : s0_q.activation;
    s1_prod_d = ProdW'(wmant) * ProdW'(amag);
    s1_neg_d  = wneg ^ aneg;
  end

  // Stage 2: apply the exponent, truncate to Q16.16 on the magnitude, then sign.
  always_comb begin
    wide      = {{(WideW-ProdW){1'b0}}, s1_prod_q} << s1_sh_q;
    pmag      = wide[WideW-1:FracDrop];
    s2_term_d = s1_neg_q ? -$signed({{(SumW-TermW){1'b0}}, pmag})
                         :  $signed({{(SumW-TermW){1'b0}}, pmag});
  end

  // Stage 3: saturating accumulate; clear on the row end.
  always_comb begin
    sum_ext  = {sum_q[SumW-1], sum_q} + {s2_term_q[SumW-1], s2_term_q};
    ovf      = sum_ext[SumW] != sum_ext[SumW-1];
    sum_new  = ovf ? (sum_ext[SumW] ? SumMin : SumMax) : sum_ext[SumW-1:0];
    flag_new = flag_q | ovf;
    sum_d    = sum_q;
    flag_d   = flag_q;
    if (acc_go) begin
      if (s2_last_q) begin
        sum_d  = '0;
        flag_d = 1'b0;
      end else begin
        sum_d  = sum_new;
        flag_d = flag_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      sum_q   <= '0;
      flag_q  <= 1'b0;
    end else begin
      s0_v_q  <= s0_v_d;
      s1_v_q  <= s1_v_d;
      s2_v_q  <= s2_v_d;
      out_v_q <= out_v_d;
      sum_q   <= sum_d;
      flag_q  <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_q <= in_item_i;
    end
    if (s0_go) begin
      s1_prod_q <= s1_prod_d;
      s1_sh_q   <= s1_sh_d;
      s1_neg_q  <= s1_neg_d;
      s1_last_q <= s0_q.last_element;
    end
    if (s1_go) begin
      s2_term_q <= s2_term_d;
      s2_last_q <= s1_last_q;
    end
    if (acc_go && s2_last_q) begin
      out_q.dot_product <= sum_new;
      out_q.overflowed  <= flag_new;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// File: tb/q2bdp_checker.sv
// Row sum predictor and result comparator for the quantized dot product block.
`timescale 1ns / 1ps

module q2bdp_checker
  import q2bdp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_item_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned rows_o,
  output int unsigned sat_rows_o
);

  localparam logic [4:0]  ExpSubnormal = 5'd0;
  localparam logic [4:0]  ExpSpecial   = 5'd31;
  localparam logic [63:0] SpecialMag   = 64'd2047 << 29;  // 65504 in 2^-24 units
  localparam int unsigned TruncShift   = 25;
  localparam logic signed [63:0] SumTop    = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] SumBottom = {1'b1, {63{1'b0}}};

  logic signed [63:0] row_sum;
  logic               row_sat;
  out_item_t          row_results_q[$];
  int unsigned        fails, rows, sat_rows;

  // Signed Q16.16 contribution of one element, truncated toward zero.
  function automatic logic signed [63:0] element_term(input in_item_t it);
    logic [4:0]          ex;
    logic [9:0]          man;
    logic                sneg, wneg, aneg;
    logic [63:0]         smag, wmag, amag, pmag;
    logic signed [63:0]  act_ext;
    logic [127:0]        full;
    ex   = it.scale_half[14:10];
    man  = it.scale_half[9:0];
    sneg = it.scale_half[15];
    if (ex == ExpSubnormal) begin
      smag = {54'd0, man};
    end else if (ex == ExpSpecial) begin
      smag = SpecialMag;
    end else begin
      smag = (64'd1024 + {54'd0, man}) << (ex - 5'd1);
    end
    // Outer codes weigh 1.5 steps, inner codes half a step; low codes are negative.
    wmag = (it.weight_code == 2'd0 || it.weight_code == 2'd3) ? 64'd3 * smag : smag;
    wneg = (it.weight_code < 2'd2) ^ sneg;
    act_ext = it.activation;
    aneg    = it.activation[31];
    amag    = aneg ? -act_ext : act_ext;
    full = wmag * amag;
    pmag = 64'(full >> TruncShift);
    return (wneg ^ aneg) ? -$signed(pmag) : $signed(pmag);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [63:0] term;
    logic signed [64:0] wide;
    out_item_t          want;
    if (!rst_ni) begin
      row_sum  = '0;
      row_sat  = 1'b0;
      row_results_q.delete();
      fails    = 0;
      rows     = 0;
      sat_rows = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        term = element_term(in_item_i);
        wide = 65'(row_sum) + 65'(term);
        // Clamp when the carry out disagrees with the sign bit.
        if (wide[64] != wide[63]) begin
          row_sum = wide[64] ? SumBottom : SumTop;
          row_sat = 1'b1;
        end else begin
          row_sum = wide[63:0];
        end
        if (in_item_i.last_element) begin
          want.dot_product = row_sum;
          want.overflowed  = row_sat;
          row_results_q.push_back(want);
          row_sum = '0;
          row_sat = 1'b0;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (row_results_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected row result: expected none, got dot_product %0d overflowed %0b",
                   $time, out_item_i.dot_product, out_item_i.overflowed);
        end else begin
          want = row_results_q.pop_front();
          rows++;
          if (want.overflowed) sat_rows++;
          if (out_item_i.dot_product !== want.dot_product) begin
            fails++;
            $display("%0t: dot_product mismatch: expected %0d, got %0d",
                     $time, want.dot_product, out_item_i.dot_product);
          end
          if (out_item_i.overflowed !== want.overflowed) begin
            fails++;
            $display("%0t: overflowed mismatch: expected %0b, got %0b",
                     $time, want.overflowed, out_item_i.overflowed);
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= row_results_q.size();
    rows_o       <= rows;
    sat_rows_o   <= sat_rows;
  end

endmodule

// File: tb/q2_block_dot_product_test.sv
// Stimulus, flow control and verdict for the quantized dot product block.
`timescale 1ns / 1ps

module q2_block_dot_product_test;
  import q2bdp_pkg::*;

  localparam int unsigned RandomItems = 960;
  localparam int unsigned HoldCycles  = 400;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;

  int unsigned fail_count, pending, rows_seen, sat_rows;
  int unsigned elements_sent;
  int unsigned burst_left = 1;
  int unsigned max_gap = 8;
  bit          hold_req = 1'b0;

  q2_block_dot_product dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  q2bdp_checker row_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .rows_o       (rows_seen),
    .sat_rows_o   (sat_rows)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic in_item_t element(input logic [1:0] code, input logic [15:0] scale,
                                       input logic [31:0] act, input logic last);
    in_item_t it;
    it.weight_code  = code;
    it.scale_half   = scale;
    it.activation   = act;
    it.last_element = last;
    return it;
  endfunction

  function automatic in_item_t random_element(input logic last);
    logic [15:0] scale;
    logic [31:0] act;
    scale = 16'($urandom());
    case ($urandom_range(0, 5))
      0: scale = {scale[15], 15'd0};
      1: scale = {scale[15], 5'd0, scale[9:0]};
      2: scale = {scale[15], 5'd31, scale[9:0]};
      3: scale = {scale[15], 5'($urandom_range(10, 20)), scale[9:0]};
      default: ;
    endcase
    act = $urandom();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: act = 32'h0000_0000;
          1: act = 32'h0000_0001;
          2: act = 32'hFFFF_FFFF;
          3: act = 32'h7FFF_FFFF;
          default: act = 32'h8000_0000;
        endcase
      end
      1, 2: act = 32'($signed(act) >>> $urandom_range(8, 24));
      default: ;
    endcase
    return element(2'($urandom_range(0, 3)), scale, act, last);
  endfunction

  // Offer one item and hold it until accepted; may insert a gap when a burst runs out.
  task automatic push_element(input in_item_t it);
    int unsigned gap;
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    elements_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (max_gap == 0 || $urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, max_gap);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic random_row(input int unsigned len);
    for (int unsigned i = 1; i <= len; i++) begin
      push_element(random_element(i == len));
    end
  endtask

  // Receiver: stall segments of varying density, plus one long hold-off on request.
  initial begin
    int unsigned seg, pct;
    forever begin
      seg = $urandom_range(20, 200);
      case ($urandom_range(0, 4))
        0, 1: pct = 0;
        2: pct = 25;
        3: pct = 50;
        default: pct = 90;
      endcase
      repeat (seg) begin
        @(posedge clk);
        if (hold_req) begin
          hold_req = 1'b0;
          out_stall <= 1'b1;
          repeat (HoldCycles) @(posedge clk);
        end
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  initial begin
    int unsigned start_count, drain;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Each code, zero and subnormal scales, extremes, infinity and NaN scales.
    push_element(element(2'd0, 16'h3C00, 32'h0001_0000, 1'b1));
    push_element(element(2'd1, 16'h3C00, 32'h0001_0000, 1'b0));
    push_element(element(2'd2, 16'h3C00, 32'h0001_0000, 1'b0));
    push_element(element(2'd3, 16'h3C00, 32'h0001_0000, 1'b1));
    push_element(element(2'd3, 16'h0000, 32'h7FFF_FFFF, 1'b0));
    push_element(element(2'd0, 16'h8000, 32'h8000_0000, 1'b1));
    push_element(element(2'd3, 16'h0001, 32'h7FFF_FFFF, 1'b0));
    push_element(element(2'd0, 16'h83FF, 32'h8000_0000, 1'b0));
    push_element(element(2'd2, 16'h0400, 32'hFFFF_FFFF, 1'b1));
    push_element(element(2'd3, 16'h7BFF, 32'h7FFF_FFFF, 1'b0));
    push_element(element(2'd0, 16'hFBFF, 32'h8000_0000, 1'b1));
    push_element(element(2'd3, 16'h7C00, 32'h0000_0001, 1'b0));
    push_element(element(2'd1, 16'hFC00, 32'h8000_0000, 1'b0));
    push_element(element(2'd2, 16'h7E00, 32'h7FFF_FFFF, 1'b0));
    push_element(element(2'd0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
    push_element(element(2'd1, 16'h3800, 32'h0000_0000, 1'b1));
    push_element(element(2'd2, 16'h5640, 32'hDEAD_BEEF, 1'b0));
    push_element(element(2'd3, 16'h2E66, 32'h1234_5678, 1'b1));

    random_row(3);

    // Hold the receiver off while short rows keep coming, so the pipe backs up.
    hold_req = 1'b1;
    max_gap  = 0;
    repeat (80) random_row($urandom_range(1, 2));
    max_gap  = 8;

    start_count = elements_sent;
    while (elements_sent - start_count < RandomItems) begin
      random_row(($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16));
    end
    in_valid <= 1'b0;

    drain = 0;
    while (pending != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);

    $display("Sent %0d elements; %0d row sums compared, %0d of them clamped at a bound.",
             elements_sent, rows_seen, sat_rows);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      if (pending != 0) $display("%0t: %0d expected row results never arrived", $time, pending);
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("TEST FAILED");
    $finish;
  end

endmodule
